// ===== hw/rtl/tof_distance_averager_top_assert.svh =====
// Assertion macros for the range-finder checker.
`ifndef TOF_DISTANCE_AVERAGER_TOP_ASSERT_SVH
`define TOF_DISTANCE_AVERAGER_TOP_ASSERT_SVH

// Property checked outside reset.
`define TOFDA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tofda check failed");

// Property checked on every edge, reset included.
`define TOFDA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tofda check failed");

`endif

// ===== hw/rtl/tofda_pkg.sv =====
`default_nettype none

package tofda_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned TEMP_W    = 8;
    localparam int unsigned CORR_W    = 16;
    localparam int unsigned DIST_W    = 11;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_PAD_W   = M_TDATA_W - CORR_W - DIST_W;

    // Window default
    localparam int unsigned WINDOW_LEN_DEF = 100;

    // Band edges and offsets
    localparam logic [CORR_W-1:0] BAND_EDGE_0 = 16'd1200;
    localparam logic [CORR_W-1:0] BAND_EDGE_1 = 16'd2000;
    localparam logic [CORR_W-1:0] BAND_EDGE_2 = 16'd3500;
    localparam logic [CORR_W-1:0] BAND_OFS_0  = 16'd250;
    localparam logic [CORR_W-1:0] BAND_OFS_1  = 16'd300;
    localparam logic [CORR_W-1:0] BAND_OFS_2  = 16'd350;
    localparam logic [CORR_W-1:0] BAND_OFS_3  = 16'd400;

    // Temperature range and speed table
    localparam int TEMP_MIN   = -40;
    localparam int TEMP_MAX   = 85;
    localparam int unsigned TEMP_STEPS = 126;
    localparam int unsigned TIDX_W     = 7;
    localparam int unsigned SPEED_W    = 25;
    localparam longint unsigned KELVIN_BASE = 273;
    localparam longint unsigned SPEED_0C    = 331;

    // Distance: round(speed * t / (20000 * 2^16))
    localparam int unsigned PROD_W     = 42;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned Q_W        = PROD_W - FRAC_W;
    localparam logic [PROD_W-1:0] DIST_RND = 42'd655360000;
    localparam int unsigned DIV_MUL_W  = 27;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 27'd109951163;
    localparam int unsigned DIV_SHIFT  = 41;
    localparam int unsigned DIVP_W     = Q_W + DIV_MUL_W;
    localparam int unsigned DRAW_W     = DIVP_W - DIV_SHIFT;
    localparam logic [DRAW_W-1:0] DIST_MAX = 12'd2047;

    // Speed of sound in Q16 for table index idx (temperature idx + TEMP_MIN)
    function automatic logic [SPEED_W-1:0] speed_q16(input int unsigned idx);
        longint unsigned num;
        longint unsigned root;
        longint unsigned bitv;
        num  = SPEED_0C * SPEED_0C * (longint'(KELVIN_BASE) + TEMP_MIN + idx);
        num  = (num << 32) / KELVIN_BASE;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (num >= root + bitv) begin
                num  = num - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return SPEED_W'(root);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tofda_cell.sv =====
`default_nettype none

// One window cell: holds a sample, takes its neighbor's on shift.
module tofda_cell #(
    parameter int unsigned DATA_W = tofda_pkg::SAMPLE_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [DATA_W-1:0] d_in,
    output logic [DATA_W-1:0] q_reg
);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift_en) begin
            q_reg <= d_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tofda_window.sv =====
`default_nettype none

// Sample window as a chain of cells plus running sum.
module tofda_window #(
    parameter int unsigned WINDOW_LEN = tofda_pkg::WINDOW_LEN_DEF,
    localparam int unsigned SUM_W     = tofda_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [tofda_pkg::SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]              sum_reg
);

    logic [tofda_pkg::SAMPLE_W-1:0] tap [WINDOW_LEN];
    logic [SUM_W-1:0]               sum_next;

    // Cell chain: head takes the new sample, tail holds the oldest
    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        if (g == 0) begin : g_head
            tofda_cell #(.DATA_W(tofda_pkg::SAMPLE_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (sample),
                .q_reg    (tap[g])
            );
        end else begin : g_body
            tofda_cell #(.DATA_W(tofda_pkg::SAMPLE_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (tap[g-1]),
                .q_reg    (tap[g])
            );
        end
    end

    // Drop oldest, add newest
    assign sum_next = sum_reg - SUM_W'(tap[WINDOW_LEN-1]) + SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (shift_en) begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tofda_ranger.sv =====
`default_nettype none

// Mean, band correction, speed lookup and distance, five pipeline stages
// after the window sum, each with its own valid and stall.
module tofda_ranger #(
    parameter int unsigned WINDOW_LEN = tofda_pkg::WINDOW_LEN_DEF,
    localparam int unsigned SUM_W     = tofda_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [tofda_pkg::TEMP_W-1:0] in_temp,
    input  logic [SUM_W-1:0]                 win_sum,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tofda_pkg::CORR_W-1:0]     out_corr,
    output logic [tofda_pkg::DIST_W-1:0]     out_dist
);

    localparam int unsigned NSTAGE     = 6;
    localparam int unsigned MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int unsigned MEAN_MUL_W = SUM_W + 2;
    localparam int unsigned MEANP_W    = SUM_W + MEAN_MUL_W;
    // Exact floor(sum / WINDOW_LEN) by rounded-up reciprocal
    localparam logic [MEAN_MUL_W-1:0] MEAN_MUL =
        MEAN_MUL_W'(((64'd1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] adv;

    logic [tofda_pkg::TIDX_W-1:0]  tidx0_reg, tidx0_next;
    logic [tofda_pkg::TIDX_W-1:0]  tidx1_reg;
    logic [tofda_pkg::CORR_W-1:0]  mean1_reg, mean1_next;
    logic [tofda_pkg::CORR_W-1:0]  corr2_reg, corr2_next;
    logic [tofda_pkg::SPEED_W-1:0] speed2_reg;
    logic [tofda_pkg::Q_W-1:0]     q3_reg, q3_next;
    logic [tofda_pkg::CORR_W-1:0]  corr3_reg;
    logic [tofda_pkg::DRAW_W-1:0]  dist4_reg, dist4_next;
    logic [tofda_pkg::CORR_W-1:0]  corr4_reg;
    logic [tofda_pkg::CORR_W-1:0]  corr5_reg;
    logic [tofda_pkg::DIST_W-1:0]  dist5_reg, dist5_next;

    logic [MEANP_W-1:0]               meanp;
    logic [tofda_pkg::CORR_W-1:0]     band_ofs;
    logic [tofda_pkg::PROD_W-1:0]     scaled;
    logic [tofda_pkg::DIVP_W-1:0]     divp;
    logic [tofda_pkg::SPEED_W-1:0]    speed_tab [tofda_pkg::TEMP_STEPS];

    // Speed table, built at elaboration
    for (genvar k = 0; k < tofda_pkg::TEMP_STEPS; k++) begin : g_spd
        localparam logic [tofda_pkg::SPEED_W-1:0] SPD = tofda_pkg::speed_q16(k);
        assign speed_tab[k] = SPD;
    end

    // Stall chain: a stage moves when empty or when the next one moves
    always_comb begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: clamp temperature into table index
    always_comb begin
        if (in_temp < tofda_pkg::TEMP_MIN) begin
            tidx0_next = '0;
        end else if (in_temp > tofda_pkg::TEMP_MAX) begin
            tidx0_next = tofda_pkg::TIDX_W'(tofda_pkg::TEMP_STEPS - 1);
        end else begin
            tidx0_next = tofda_pkg::TIDX_W'(int'(in_temp) - tofda_pkg::TEMP_MIN);
        end
    end

    // Stage 1: mean by reciprocal multiply
    assign meanp      = MEANP_W'(win_sum) * MEANP_W'(MEAN_MUL);
    assign mean1_next = meanp[MEAN_SHIFT +: tofda_pkg::CORR_W];

    // Stage 2: band offset, clamp at zero
    always_comb begin
        if (mean1_reg < tofda_pkg::BAND_EDGE_0) begin
            band_ofs = tofda_pkg::BAND_OFS_0;
        end else if (mean1_reg < tofda_pkg::BAND_EDGE_1) begin
            band_ofs = tofda_pkg::BAND_OFS_1;
        end else if (mean1_reg < tofda_pkg::BAND_EDGE_2) begin
            band_ofs = tofda_pkg::BAND_OFS_2;
        end else begin
            band_ofs = tofda_pkg::BAND_OFS_3;
        end
        corr2_next = (mean1_reg > band_ofs) ? (mean1_reg - band_ofs) : '0;
    end

    // Stage 3: speed * time plus half divisor, drop fraction
    assign scaled  = tofda_pkg::PROD_W'(speed2_reg) * tofda_pkg::PROD_W'(corr2_reg)
                   + tofda_pkg::DIST_RND;
    assign q3_next = scaled[tofda_pkg::FRAC_W +: tofda_pkg::Q_W];

    // Stage 4: divide by 20000 via reciprocal
    assign divp       = tofda_pkg::DIVP_W'(q3_reg) * tofda_pkg::DIVP_W'(tofda_pkg::DIV_MUL);
    assign dist4_next = divp[tofda_pkg::DIV_SHIFT +: tofda_pkg::DRAW_W];

    // Stage 5: saturate
    assign dist5_next = (dist4_reg > tofda_pkg::DIST_MAX)
                      ? tofda_pkg::DIST_W'(tofda_pkg::DIST_MAX)
                      : dist4_reg[tofda_pkg::DIST_W-1:0];

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            tidx0_reg <= tidx0_next;
        end
        if (adv[1]) begin
            mean1_reg <= mean1_next;
            tidx1_reg <= tidx0_reg;
        end
        if (adv[2]) begin
            corr2_reg  <= corr2_next;
            speed2_reg <= speed_tab[tidx1_reg];
        end
        if (adv[3]) begin
            q3_reg    <= q3_next;
            corr3_reg <= corr2_reg;
        end
        if (adv[4]) begin
            dist4_reg <= dist4_next;
            corr4_reg <= corr3_reg;
        end
        if (adv[5]) begin
            dist5_reg <= dist5_next;
            corr5_reg <= corr4_reg;
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_corr  = corr5_reg;
    assign out_dist  = dist5_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tof_distance_averager_top.sv =====
// Channel  | Dir | Ports                     | Beat contents
// ---------+-----+---------------------------+---------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata | flight_time_us, temperature_c
// m_       | out | m_tvalid m_tready m_tdata | corrected_time_us, range_cm
//
// One beat accepted per cycle while s_tready is high; a result passes through
// the window/sum register, mean multiply, band and speed lookup, speed * time,
// reciprocal divide and output register.
// Reset clears all window cells, the running sum and every stage valid.
// A stalled output fills stage by stage; s_tready drops only when all six
// stages hold a result.
`default_nettype none

module tof_distance_averager_top #(
    parameter int unsigned WINDOW_LEN = tofda_pkg::WINDOW_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] flight_time_us, [23:16] temperature_c
    input  logic [tofda_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] corrected_time_us, [26:16] range_cm, [31:27] zero
    output logic [tofda_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned SUM_W = tofda_pkg::SAMPLE_W + $clog2(WINDOW_LEN);

    logic                          s_accept;
    logic [SUM_W-1:0]              win_sum;
    logic [tofda_pkg::CORR_W-1:0]  out_corr;
    logic [tofda_pkg::DIST_W-1:0]  out_dist;

    assign s_accept = s_tvalid && s_tready;

    // Window of recent flight times
    tofda_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s_accept),
        .sample   (s_tdata[tofda_pkg::SAMPLE_W-1:0]),
        .sum_reg  (win_sum)
    );

    // Mean, correction and distance pipeline
    tofda_ranger #(.WINDOW_LEN(WINDOW_LEN)) u_ranger (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_temp   (s_tdata[tofda_pkg::SAMPLE_W +: tofda_pkg::TEMP_W]),
        .win_sum   (win_sum),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_corr  (out_corr),
        .out_dist  (out_dist)
    );

    assign m_tdata = {{tofda_pkg::M_PAD_W{1'b0}}, out_dist, out_corr};

endmodule

`default_nettype wire

// ===== hw/rtl/tofda_checker.sv =====
`default_nettype none
`include "tof_distance_averager_top_assert.svh"

// Port-level checks on the range finder.
module tofda_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tofda_pkg::M_TDATA_W-1:0] m_tdata
);

    logic corr_zero;
    logic upper_zero;

    assign corr_zero  = (m_tdata[tofda_pkg::CORR_W-1:0] == '0);
    assign upper_zero = (m_tdata[tofda_pkg::M_TDATA_W-1:tofda_pkg::CORR_W] == '0);

    // Held result keeps its beat
    `TOFDA_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // Reset empties the pipeline
    `TOFDA_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid)

    // Empty pipeline always takes input
    `TOFDA_ASSERT(a_ready_empty, aclk, aresetn, !m_tvalid |-> s_tready)

    // Zero time gives zero distance, pad bits stay clear
    `TOFDA_ASSERT(a_zero_dist, aclk, aresetn, m_tvalid && corr_zero |-> upper_zero)

endmodule

bind tof_distance_averager_top tofda_checker u_tofda_checker (.*);

`default_nettype wire

// ===== verif/tb_tof_distance_averager_top.sv =====
`default_nettype none

module tb_tof_distance_averager_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Predictor constants
    localparam int unsigned       RING_LEN      = 100;
    localparam longint unsigned   KELVIN_0C     = 273;
    localparam longint unsigned   SOUND_0C      = 331;
    localparam int                T_LOW         = -40;
    localparam int                T_HIGH        = 85;
    localparam longint unsigned   DIST_DEN      = 64'd20000 * 64'd65536;
    localparam longint unsigned   DIST_HALF     = 64'd20000 * 64'd32768;
    localparam longint unsigned   DIST_SAT      = 2047;
    localparam int                QUIET_LIMIT   = 5000;
    localparam int                DRAIN_CYCLES  = 20;
    localparam int                PHASE_ITEMS   = 425;

    // Random segment shapes
    typedef enum int {
        SEG_HOLD,
        SEG_FULL,
        SEG_LOW,
        SEG_MID
    } seg_kind_t;

    typedef struct packed {
        logic [tofda_pkg::CORR_W-1:0] corr;
        logic [tofda_pkg::DIST_W-1:0] range_cm;
    } range_t;

    typedef struct {
        logic [tofda_pkg::SAMPLE_W-1:0] flight;
        byte                            temp;
        bit                             typed;
        range_t                         want;
    } beat_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tofda_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tofda_pkg::M_TDATA_W-1:0] m_tdata;

    // Predictor state
    logic [tofda_pkg::SAMPLE_W-1:0] sample_ring [RING_LEN];
    int unsigned                    ring_total = 0;
    int unsigned                    ring_head  = 0;
    range_t                         pending_ranges [$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Mean values worth parking the whole window on: clamp and band edges, zero, full scale
    logic [tofda_pkg::SAMPLE_W-1:0] hold_levels [14] = '{
        16'd249, 16'd250, 16'd251, 16'd1199, 16'd1200, 16'd1201, 16'd1999,
        16'd2000, 16'd2001, 16'd3499, 16'd3500, 16'd3501, 16'd0, 16'd65535
    };

    // Directed beats; only the first few carry a hand-typed result
    beat_row_t directed_rows [22] = '{
        '{16'd0,      0,    1'b1, '{16'd0, 11'd0}},  // fresh window, all zero
        '{16'd25000,  85,   1'b1, '{16'd0, 11'd0}},  // mean equals offset
        '{16'd100,    -40,  1'b1, '{16'd1, 11'd0}},  // one over the offset
        '{16'd65535,  -128, 1'b0, '0},
        '{16'd65535,  127,  1'b0, '0},
        '{16'd65535,  -41,  1'b0, '0},
        '{16'd65535,  86,   1'b0, '0},
        '{16'd65535,  -1,   1'b0, '0},
        '{16'h5555,   85,   1'b0, '0},
        '{16'hAAAA,   -86,  1'b0, '0},
        '{16'hFFFF,   127,  1'b0, '0},
        '{16'h8000,   -128, 1'b0, '0},
        '{16'h7FFF,   1,    1'b0, '0},
        '{16'd1,      0,    1'b0, '0},
        '{16'd65535,  -40,  1'b0, '0},
        '{16'd65535,  -20,  1'b0, '0},
        '{16'd65535,  0,    1'b0, '0},
        '{16'd65535,  20,   1'b0, '0},
        '{16'd65535,  40,   1'b0, '0},
        '{16'd65535,  60,   1'b0, '0},
        '{16'd65535,  85,   1'b0, '0},
        '{16'd0,      85,   1'b0, '0}
    };

    tof_distance_averager_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // [15:0] flight_time_us, [23:16] temperature_c
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // [15:0] corrected_time_us, [26:16] range_cm, [31:27] zero
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Speed of sound in Q16: floor of the exact root, found bit by bit
    function automatic longint unsigned sound_speed_q16(input byte temp);
        int              t;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        t = temp;
        if (t < T_LOW) begin
            t = T_LOW;
        end
        if (t > T_HIGH) begin
            t = T_HIGH;
        end
        radicand = SOUND_0C * SOUND_0C * longint'(KELVIN_0C + t);
        radicand = (radicand << 32) / KELVIN_0C;
        root = 0;
        for (int b = 27; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Push one flight time through the window and work out the range
    function automatic range_t advance_ranging(input logic [tofda_pkg::SAMPLE_W-1:0] flight,
                                               input byte temp);
        int unsigned     mean;
        int unsigned     offset;
        longint unsigned dist_raw;
        range_t          res;
        ring_total = ring_total - sample_ring[ring_head] + flight;
        sample_ring[ring_head] = flight;
        ring_head = (ring_head == RING_LEN - 1) ? 0 : ring_head + 1;
        mean = ring_total / RING_LEN;
        if (mean < 1200) begin
            offset = 250;
        end else if (mean < 2000) begin
            offset = 300;
        end else if (mean < 3500) begin
            offset = 350;
        end else begin
            offset = 400;
        end
        res.corr = (mean > offset) ? tofda_pkg::CORR_W'(mean - offset) : '0;
        dist_raw = (sound_speed_q16(temp) * longint'(res.corr) + DIST_HALF) / DIST_DEN;
        if (dist_raw > DIST_SAT) begin
            dist_raw = DIST_SAT;
        end
        res.range_cm = tofda_pkg::DIST_W'(dist_raw);
        return res;
    endfunction

    // Offer one beat, hold it until taken, then log what should come back
    task automatic send_beat(input logic [tofda_pkg::SAMPLE_W-1:0] flight, input byte temp,
                             input bit typed, input range_t typed_res);
        range_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, flight};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = advance_ranging(flight, temp);
        pending_ranges.push_back(typed ? typed_res : predicted);
    endtask

    // Mostly in the sensor's range, sometimes anywhere in the byte
    function automatic byte pick_temp();
        if ($urandom_range(4) == 0) begin
            return byte'($urandom_range(255));
        end
        return byte'(int'($urandom_range(125)) + T_LOW);
    endfunction

    // Segments of related samples so the mean settles on chosen levels
    task automatic random_beats(input int count);
        int                             sent;
        int                             len;
        int                             pick;
        seg_kind_t                      kind;
        logic [tofda_pkg::SAMPLE_W-1:0] level;
        logic [tofda_pkg::SAMPLE_W-1:0] flight;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(9);
            kind = (pick < 4) ? SEG_HOLD : (pick < 6) ? SEG_FULL :
                   (pick < 8) ? SEG_LOW : SEG_MID;
            level = hold_levels[$urandom_range(13)];
            len = (kind == SEG_HOLD) ? 100 + $urandom_range(8) : 20 + $urandom_range(40);
            for (int k = 0; (k < len) && (sent < count); k++) begin
                case (kind)
                    SEG_HOLD: flight = level;
                    SEG_FULL: flight = tofda_pkg::SAMPLE_W'($urandom_range(65535));
                    SEG_LOW:  flight = tofda_pkg::SAMPLE_W'($urandom_range(800));
                    default:  flight = tofda_pkg::SAMPLE_W'($urandom_range(4000, 800));
                endcase
                send_beat(flight, pick_temp(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Result checker and receiver backpressure
    always @(posedge aclk) begin
        range_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ranges.size() == 0) begin
                $error("result beat with nothing pending: corrected_time_us %0d range_cm %0d",
                       m_tdata[15:0], m_tdata[26:16]);
                errors++;
            end else begin
                want = pending_ranges.pop_front();
                if (m_tdata[15:0] !== want.corr) begin
                    $error("corrected_time_us mismatch: expected %0d, actual %0d",
                           want.corr, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[26:16] !== want.range_cm) begin
                    $error("range_cm mismatch: expected %0d, actual %0d",
                           want.range_cm, m_tdata[26:16]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long with no beat on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        foreach (sample_ring[i]) begin
            sample_ring[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].flight, directed_rows[i].temp,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part over the idling phases
        random_beats(PHASE_ITEMS);
        send_idle_pct  = 49;
        recv_stall_pct = 0;
        random_beats(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        random_beats(PHASE_ITEMS);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        random_beats(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        // Drain, then give stray beats a chance to show up
        while (pending_ranges.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
